@@ rtl/bct_pkg.sv @@
// Shared widths, constants and handshake structs of the binary contour tracer.
// Used by the pixel store, the divider and the tracer core; no dependencies.
package bct_pkg;

   // Largest image the pixel store holds
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // Configuration port
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Input operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Field widths
   localparam int OUT_W = 9;
   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Pixel store geometry: address is {row, column}
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int ADDR_W    = COL_W + ROW_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   // Clamped dimension, raster position and signed corner coordinate widths
   localparam int DIM_W  = CFG_W;
   localparam int POS_W  = ADDR_W + 1;
   localparam int SPAN_A = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int SPAN_W = (SPAN_A > DIM_W) ? SPAN_A : DIM_W;
   localparam int EXT_W  = SPAN_W + 1;
   localparam int CRD_W  = SPAN_W + 2;

   // Divider step counter
   localparam int DIV_CNT_W = $clog2(POS_W + 1);

   // Pixel store access for one cycle
   typedef struct packed {
      logic              img_we;
      logic              img_wdata;
      logic              mask_we;
      logic              mask_wdata;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] img_raddr;
      logic [ADDR_W-1:0] mask_raddr;
   } bct_mem_req_type;

   // Divider launch
   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] dividend;
      logic [DIM_W-1:0] divisor;
   } bct_div_req_type;

   // Divider result
   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] quotient;
      logic [DIM_W-1:0] remainder;
   } bct_div_rsp_type;

endpackage

@@ rtl/bct_pixel_store.sv @@
// Image bitmap and start mask memories, one write and one registered read each.
// Depends on bct_pkg for geometry and the access struct.
module bct_pixel_store (
   input  logic                     clock,
   input  bct_pkg::bct_mem_req_type mem_req,
   output logic                     img_rdata,
   output logic                     mask_rdata
);

   logic img_mem_ff  [bct_pkg::MEM_DEPTH];
   logic mask_mem_ff [bct_pkg::MEM_DEPTH];
   logic img_rdata_ff;
   logic mask_rdata_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (mem_req.img_we) begin
         img_mem_ff[mem_req.waddr] <= mem_req.img_wdata;
      end
      if (mem_req.mask_we) begin
         mask_mem_ff[mem_req.waddr] <= mem_req.mask_wdata;
      end
      img_rdata_ff  <= img_mem_ff[mem_req.img_raddr];
      mask_rdata_ff <= mask_mem_ff[mem_req.mask_raddr];
   end

   assign img_rdata  = img_rdata_ff;
   assign mask_rdata = mask_rdata_ff;

endmodule

@@ rtl/bct_divider.sv @@
// Restoring divider, one quotient bit per cycle: raster position by image width.
// Depends on bct_pkg for widths and the request and result structs.
module bct_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  bct_pkg::bct_div_req_type div_req,
   output bct_pkg::bct_div_rsp_type div_rsp
);

   logic [bct_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bct_pkg::POS_W-1:0]     quo_ff, quo_in;
   logic [bct_pkg::DIM_W-1:0]     rem_ff, rem_in;
   logic [bct_pkg::DIM_W-1:0]     dvs_ff, dvs_in;
   logic [bct_pkg::DIM_W:0]       trial;

   // One shift and subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[bct_pkg::POS_W-1]};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = bct_pkg::DIV_CNT_W'(bct_pkg::POS_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = bct_pkg::DIM_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[bct_pkg::POS_W-2:0], 1'b1};
         end else begin
            rem_in = trial[bct_pkg::DIM_W-1:0];
            quo_in = {quo_ff[bct_pkg::POS_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bct_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ rtl/binary_contour_tracer_core.sv @@
// Binary contour tracer: bitmap load, start scan and square tracing sequencer.
// Depends on bct_pkg, bct_pixel_store and bct_divider.
//
// Use: req_ words with req_operation load stream pixels in raster order
// (1 is black); req_ words with req_operation fetch each return one rsp_
// word: the next corner of the current contour, the repeated start corner
// with rsp_contour_end set, or rsp_scan_done once no start pixel is left.
// Loads return nothing. csr_we writes image_width (index 0) or image_height
// (index 1); the user must write only while the block is idle, which the
// block does not enforce. A load is written in LOAD_WR. A fetch along a
// contour passes EMIT, MOVE, RD_LEFT, RD_RIGHT and TURN; the
// single image read port fetches the left and right pixels in turn. A
// fetch that starts a contour first scans start mask pixels, one mask read
// and one check each. After a dimension write the block re-derives the load
// and scan positions in the bit-serial divider before it takes a word.
// Reset clears positions, phase, count and sets both dimensions to 256; the
// bitmap holds no reset value and must be loaded before it is traced.
// A result waits in the rsp_ register while rsp_ready is low; a fetch that
// needs the register then holds until it is taken, loads go on.
module binary_contour_tracer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic                                req_pixel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bct_pkg::OUT_W-1:0]           rsp_corner_x,
   output logic [bct_pkg::OUT_W-1:0]           rsp_corner_y,
   output logic                                rsp_contour_end,
   output logic                                rsp_scan_done,
   output logic [bct_pkg::CNT_W-1:0]           rsp_contour_count,
   input  logic                                csr_we,
   input  logic [bct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bct_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int CRD_W = bct_pkg::CRD_W;
   localparam int COL_W = bct_pkg::COL_W;
   localparam int ROW_W = bct_pkg::ROW_W;
   localparam int POS_W = bct_pkg::POS_W;
   localparam int DIM_W = bct_pkg::DIM_W;
   localparam int EXT_W = bct_pkg::EXT_W;
   localparam int OUT_W = bct_pkg::OUT_W;

   // Sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_LOAD_WR  = 4'd1;
   localparam logic [3:0] ST_SCAN_RD  = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK = 4'd3;
   localparam logic [3:0] ST_EMIT     = 4'd4;
   localparam logic [3:0] ST_MOVE     = 4'd5;
   localparam logic [3:0] ST_RD_LEFT  = 4'd6;
   localparam logic [3:0] ST_RD_RIGHT = 4'd7;
   localparam logic [3:0] ST_TURN     = 4'd8;
   localparam logic [3:0] ST_DIV_LOAD = 4'd9;
   localparam logic [3:0] ST_DIV_SCAN = 4'd10;

   // Headings, counterclockwise
   localparam logic [1:0] HEAD_EAST  = 2'd0;
   localparam logic [1:0] HEAD_NORTH = 2'd1;
   localparam logic [1:0] HEAD_WEST  = 2'd2;
   localparam logic [1:0] HEAD_SOUTH = 2'd3;

   // Trace phases
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_TRACE = 2'd1;
   localparam logic [1:0] PHASE_CLOSE = 2'd2;

   // Kinds of result word
   localparam logic [1:0] RES_POINT = 2'd0;
   localparam logic [1:0] RES_CLOSE = 2'd1;
   localparam logic [1:0] RES_DONE  = 2'd2;

   localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);

   logic [bct_pkg::CFG_W-1:0] width_ff, width_in;
   logic [bct_pkg::CFG_W-1:0] height_ff, height_in;
   logic [3:0]                state_ff, state_in;
   logic                      renorm_ff, renorm_in;
   logic [POS_W-1:0]          load_pos_ff, load_pos_in;
   logic [COL_W-1:0]          load_col_ff, load_col_in;
   logic [POS_W-1:0]          load_row_ff, load_row_in;
   logic [POS_W-1:0]          scan_pos_ff, scan_pos_in;
   logic [COL_W-1:0]          scan_col_ff, scan_col_in;
   logic [POS_W-1:0]          scan_row_ff, scan_row_in;
   logic signed [CRD_W-1:0]   cur_x_ff, cur_x_in;
   logic signed [CRD_W-1:0]   cur_y_ff, cur_y_in;
   logic signed [CRD_W-1:0]   start_x_ff, start_x_in;
   logic signed [CRD_W-1:0]   start_y_ff, start_y_in;
   logic [1:0]                head_ff, head_in;
   logic [1:0]                phase_ff, phase_in;
   logic [bct_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      pix_ff, pix_in;
   logic [1:0]                kind_ff, kind_in;
   logic                      left_ff, left_in;
   logic                      inrange_ff, inrange_in;
   logic [COL_W-1:0]          cand_col_ff, cand_col_in;
   logic [ROW_W-1:0]          cand_row_ff, cand_row_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]          rsp_x_ff, rsp_x_in;
   logic [OUT_W-1:0]          rsp_y_ff, rsp_y_in;
   logic                      rsp_end_ff, rsp_end_in;
   logic                      rsp_done_ff, rsp_done_in;
   logic [bct_pkg::CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [DIM_W-1:0]          eff_w;
   logic [DIM_W-1:0]          eff_h;
   logic                      dims_zero;
   logic [ROW_W-1:0]          load_row_above;
   logic                      pick_left;
   logic                      pick_dx;
   logic                      pick_dy;
   logic signed [CRD_W-1:0]   pick_x;
   logic signed [CRD_W-1:0]   pick_y;
   logic                      pick_in_area;
   logic                      right_black;
   logic [1:0]                turn_head;
   logic [bct_pkg::CNT_W-1:0] count_inc;

   bct_pkg::bct_mem_req_type  mem_req;
   logic                      img_rdata;
   logic                      mask_rdata;
   bct_pkg::bct_div_req_type  div_req;
   bct_pkg::bct_div_rsp_type  div_rsp;

   // True when pixel (x,y) lies inside the active image
   function automatic logic in_area(input logic signed [CRD_W-1:0] x,
                                    input logic signed [CRD_W-1:0] y,
                                    input logic [DIM_W-1:0] w,
                                    input logic [DIM_W-1:0] h);
      logic ok;
      ok = !x[CRD_W-1] && !y[CRD_W-1] && (x[CRD_W-2:0] < (CRD_W-1)'(w)) &&
           (y[CRD_W-2:0] < (CRD_W-1)'(h));
      return ok;
   endfunction

   // Store address of pixel (x,y)
   function automatic logic [bct_pkg::ADDR_W-1:0] pix_addr(
         input logic signed [CRD_W-1:0] x, input logic signed [CRD_W-1:0] y);
      logic [bct_pkg::ADDR_W-1:0] a;
      a = {y[ROW_W-1:0], x[COL_W-1:0]};
      return a;
   endfunction

   // True when the column after col closes a row of width w
   function automatic logic row_wraps(input logic [COL_W-1:0] col,
                                      input logic [DIM_W-1:0] w);
      logic wr;
      wr = (EXT_W'(col) + EXT_W'(1)) == EXT_W'(w);
      return wr;
   endfunction

   bct_pixel_store u_store (
      .clock      (clock),
      .mem_req    (mem_req),
      .img_rdata  (img_rdata),
      .mask_rdata (mask_rdata)
   );

   bct_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Clamp dimensions to the store size
   assign eff_w     = (int'(width_ff) > bct_pkg::MAX_WIDTH) ?
                      DIM_W'(bct_pkg::MAX_WIDTH) : width_ff;
   assign eff_h     = (int'(height_ff) > bct_pkg::MAX_HEIGHT) ?
                      DIM_W'(bct_pkg::MAX_HEIGHT) : height_ff;
   assign dims_zero = (eff_w == '0) || (eff_h == '0);

   assign load_row_above = load_row_ff[ROW_W-1:0] - ROW_W'(1);
   assign count_inc      = (count_ff == bct_pkg::CNT_MAX) ? count_ff : count_ff + 1'b1;

   // Pick the left-front or right-front pixel of the corner for this heading
   assign pick_left = (state_ff == ST_RD_LEFT);
   always_comb begin
      case (head_ff)
         HEAD_EAST: begin
            pick_dx = 1'b0;
            pick_dy = pick_left;
         end
         HEAD_NORTH: begin
            pick_dx = pick_left;
            pick_dy = 1'b1;
         end
         HEAD_WEST: begin
            pick_dx = 1'b1;
            pick_dy = !pick_left;
         end
         default: begin
            pick_dx = !pick_left;
            pick_dy = 1'b0;
         end
      endcase
   end
   assign pick_x       = cur_x_ff - $signed({{(CRD_W-1){1'b0}}, pick_dx});
   assign pick_y       = cur_y_ff - $signed({{(CRD_W-1){1'b0}}, pick_dy});
   assign pick_in_area = in_area(pick_x, pick_y, eff_w, eff_h);

   // Turn left on black left-front, right on white right-front
   assign right_black = img_rdata && inrange_ff;
   always_comb begin
      if (left_ff) begin
         turn_head = head_ff + 2'd1;
      end else if (!right_black) begin
         turn_head = head_ff + 2'd3;
      end else begin
         turn_head = head_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !renorm_ff;

   // Sequencer
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      state_in     = state_ff;
      renorm_in    = renorm_ff;
      load_pos_in  = load_pos_ff;
      load_col_in  = load_col_ff;
      load_row_in  = load_row_ff;
      scan_pos_in  = scan_pos_ff;
      scan_col_in  = scan_col_ff;
      scan_row_in  = scan_row_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      head_in      = head_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      pix_in       = pix_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      inrange_in   = inrange_ff;
      cand_col_in  = cand_col_ff;
      cand_row_in  = cand_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_count_in = rsp_count_ff;
      mem_req      = '0;
      div_req      = '0;
      div_req.dividend = scan_pos_ff;
      div_req.divisor  = eff_w;

      case (state_ff)
         ST_IDLE: begin
            // read the pixel above the next load slot ahead of time
            mem_req.img_raddr = {load_row_above, load_col_ff};
            if (renorm_ff) begin
               renorm_in = 1'b0;
               if (!dims_zero) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = load_pos_ff;
                  state_in         = ST_DIV_LOAD;
               end
            end else if (req_valid) begin
               if (req_operation == bct_pkg::OP_LOAD) begin
                  pix_in = req_pixel_value;
                  if (!dims_zero && (load_row_ff < POS_W'(eff_h))) begin
                     state_in = ST_LOAD_WR;
                  end
               end else begin
                  case (phase_ff)
                     PHASE_CLOSE: begin
                        kind_in  = RES_CLOSE;
                        phase_in = PHASE_IDLE;
                        state_in = ST_EMIT;
                     end
                     PHASE_TRACE: begin
                        kind_in  = RES_POINT;
                        state_in = ST_EMIT;
                     end
                     default: begin
                        phase_in = PHASE_IDLE;
                        if (dims_zero) begin
                           kind_in  = RES_DONE;
                           state_in = ST_EMIT;
                        end else begin
                           state_in = ST_SCAN_RD;
                        end
                     end
                  endcase
               end
            end
         end

         ST_LOAD_WR: begin
            // store pixel and its start mark, advance the load slot
            mem_req.img_we     = 1'b1;
            mem_req.img_wdata  = pix_ff;
            mem_req.mask_we    = 1'b1;
            mem_req.mask_wdata = pix_ff && ((load_row_ff == '0) || !img_rdata);
            mem_req.waddr      = {load_row_ff[ROW_W-1:0], load_col_ff};
            load_pos_in        = load_pos_ff + 1'b1;
            if (row_wraps(load_col_ff, eff_w)) begin
               load_col_in = '0;
               load_row_in = load_row_ff + 1'b1;
            end else begin
               load_col_in = load_col_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end

         ST_SCAN_RD: begin
            if (scan_row_ff >= POS_W'(eff_h)) begin
               kind_in  = RES_DONE;
               state_in = ST_EMIT;
            end else begin
               mem_req.mask_raddr = {scan_row_ff[ROW_W-1:0], scan_col_ff};
               cand_col_in        = scan_col_ff;
               cand_row_in        = scan_row_ff[ROW_W-1:0];
               scan_pos_in        = scan_pos_ff + 1'b1;
               if (row_wraps(scan_col_ff, eff_w)) begin
                  scan_col_in = '0;
                  scan_row_in = scan_row_ff + 1'b1;
               end else begin
                  scan_col_in = scan_col_ff + 1'b1;
               end
               state_in = ST_SCAN_CHK;
            end
         end

         ST_SCAN_CHK: begin
            if (mask_rdata) begin
               start_x_in = $signed({{(CRD_W-COL_W){1'b0}}, cand_col_ff});
               start_y_in = $signed({{(CRD_W-ROW_W){1'b0}}, cand_row_ff});
               cur_x_in   = $signed({{(CRD_W-COL_W){1'b0}}, cand_col_ff});
               cur_y_in   = $signed({{(CRD_W-ROW_W){1'b0}}, cand_row_ff});
               head_in    = HEAD_EAST;
               kind_in    = RES_POINT;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end

         ST_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               case (kind_ff)
                  RES_CLOSE: begin
                     rsp_x_in     = start_x_ff[OUT_W-1:0];
                     rsp_y_in     = start_y_ff[OUT_W-1:0];
                     rsp_end_in   = 1'b1;
                     rsp_done_in  = 1'b0;
                     rsp_count_in = count_inc;
                     count_in     = count_inc;
                     state_in     = ST_IDLE;
                  end
                  RES_DONE: begin
                     rsp_x_in     = '0;
                     rsp_y_in     = '0;
                     rsp_end_in   = 1'b0;
                     rsp_done_in  = 1'b1;
                     rsp_count_in = count_ff;
                     state_in     = ST_IDLE;
                  end
                  default: begin
                     rsp_x_in     = cur_x_ff[OUT_W-1:0];
                     rsp_y_in     = cur_y_ff[OUT_W-1:0];
                     rsp_end_in   = 1'b0;
                     rsp_done_in  = 1'b0;
                     rsp_count_in = count_ff;
                     state_in     = ST_MOVE;
                  end
               endcase
            end
         end

         ST_MOVE: begin
            // drop the start mark below-right of the corner, step ahead
            if (in_area(cur_x_ff, cur_y_ff, eff_w, eff_h)) begin
               mem_req.mask_we    = 1'b1;
               mem_req.mask_wdata = 1'b0;
               mem_req.waddr      = pix_addr(cur_x_ff, cur_y_ff);
            end
            case (head_ff)
               HEAD_EAST:  cur_x_in = cur_x_ff + CRD_ONE;
               HEAD_NORTH: cur_y_in = cur_y_ff - CRD_ONE;
               HEAD_WEST:  cur_x_in = cur_x_ff - CRD_ONE;
               default:    cur_y_in = cur_y_ff + CRD_ONE;
            endcase
            state_in = ST_RD_LEFT;
         end

         ST_RD_LEFT: begin
            mem_req.img_raddr = pix_addr(pick_x, pick_y);
            inrange_in        = pick_in_area;
            state_in          = ST_RD_RIGHT;
         end

         ST_RD_RIGHT: begin
            left_in           = img_rdata && inrange_ff;
            mem_req.img_raddr = pix_addr(pick_x, pick_y);
            inrange_in        = pick_in_area;
            state_in          = ST_TURN;
         end

         ST_TURN: begin
            head_in = turn_head;
            if ((cur_x_ff == start_x_ff) && (cur_y_ff == start_y_ff) &&
                (turn_head == HEAD_EAST)) begin
               phase_in = PHASE_CLOSE;
            end else begin
               phase_in = PHASE_TRACE;
            end
            state_in = ST_IDLE;
         end

         ST_DIV_LOAD: begin
            // split the load position, then launch the scan position
            if (div_rsp.done) begin
               load_col_in   = COL_W'(div_rsp.remainder);
               load_row_in   = div_rsp.quotient;
               div_req.start = 1'b1;
               state_in      = ST_DIV_SCAN;
            end
         end

         ST_DIV_SCAN: begin
            if (div_rsp.done) begin
               scan_col_in = COL_W'(div_rsp.remainder);
               scan_row_in = div_rsp.quotient;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; a new dimension re-derives both positions
      if (csr_we) begin
         renorm_in = 1'b1;
         if (csr_index == bct_pkg::CSR_IMAGE_WIDTH) begin
            width_in = csr_wdata;
         end
         if (csr_index == bct_pkg::CSR_IMAGE_HEIGHT) begin
            height_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bct_pkg::CFG_W'(256);
         height_ff    <= bct_pkg::CFG_W'(256);
         state_ff     <= ST_IDLE;
         renorm_ff    <= 1'b0;
         load_pos_ff  <= '0;
         load_col_ff  <= '0;
         load_row_ff  <= '0;
         scan_pos_ff  <= '0;
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         head_ff      <= HEAD_EAST;
         phase_ff     <= PHASE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         state_ff     <= state_in;
         renorm_ff    <= renorm_in;
         load_pos_ff  <= load_pos_in;
         load_col_ff  <= load_col_in;
         load_row_ff  <= load_row_in;
         scan_pos_ff  <= scan_pos_in;
         scan_col_ff  <= scan_col_in;
         scan_row_ff  <= scan_row_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         head_ff      <= head_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff       <= pix_in;
      kind_ff      <= kind_in;
      left_ff      <= left_in;
      inrange_ff   <= inrange_in;
      cand_col_ff  <= cand_col_in;
      cand_row_ff  <= cand_row_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_corner_x      = rsp_x_ff;
   assign rsp_corner_y      = rsp_y_ff;
   assign rsp_contour_end   = rsp_end_ff;
   assign rsp_scan_done     = rsp_done_ff;
   assign rsp_contour_count = rsp_count_ff;

endmodule

@@ rtl/bct_checker.sv @@
// Port-level checks of the binary contour tracer, bound to the core.
// Depends on bct_pkg for port widths.
module bct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_operation,
   input logic                          req_pixel_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bct_pkg::OUT_W-1:0]     rsp_corner_x,
   input logic [bct_pkg::OUT_W-1:0]     rsp_corner_y,
   input logic                          rsp_contour_end,
   input logic                          rsp_scan_done,
   input logic [bct_pkg::CNT_W-1:0]     rsp_contour_count,
   input logic                          csr_we,
   input logic [bct_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [bct_pkg::CFG_W-1:0]     csr_wdata
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_corner_x) &&
      $stable(rsp_corner_y) && $stable(rsp_contour_end) &&
      $stable(rsp_scan_done) && $stable(rsp_contour_count))
      else $error("result word changed while stalled");

   // Scan done carries no point
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_done |->
      (rsp_corner_x == '0) && (rsp_corner_y == '0) && !rsp_contour_end)
      else $error("scan done word carries point fields");

   // A closed contour is counted
   a_end_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contour_end |-> (rsp_contour_count != '0))
      else $error("contour end with zero count");

   // Reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind binary_contour_tracer_core bct_checker u_bct_checker (.*);

@@ bench/tb_binary_contour_tracer_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for binary_contour_tracer_core: loads bitmaps, fetches contour
// corners and compares every rsp_ word with a behavioral tracer kept in this file.
// Depends on bct_pkg and the tracer core RTL.
module tb_binary_contour_tracer_core;
   import bct_pkg::*;

   localparam int MEM_ROW       = MAX_WIDTH;   // pixel store row pitch
   localparam int STRIP_WIDTH   = 8;           // width used while rows are added
   localparam int STRIP_ROWS    = 32;          // rows at the end of the strip test
   localparam int SETTLE_CYCLES = 8;           // covers a load still in flight
   localparam int LONG_HOLD     = 300;         // receiver hold-off under pressure
   localparam int CYCLE_LIMIT   = 500000;

   typedef enum bit [1:0] {DIR_EAST, DIR_NORTH, DIR_WEST, DIR_SOUTH} dir_t;
   typedef enum bit [1:0] {SEEK, FOLLOW, CLOSING} trace_state_t;

   typedef struct packed {
      logic [OUT_W-1:0] col;
      logic [OUT_W-1:0] row;
      logic             closing;
      logic             exhausted;
      logic [CNT_W-1:0] total;
   } corner_word_t;

   // Block ports; the inputs are known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_operation = OP_LOAD;
   logic                 req_pixel_value = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_W-1:0]     rsp_corner_x;
   logic [OUT_W-1:0]     rsp_corner_y;
   logic                 rsp_contour_end;
   logic                 rsp_scan_done;
   logic [CNT_W-1:0]     rsp_contour_count;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // Tracer state mirrored by the bench
   bit           img_px   [MEM_DEPTH];
   bit           start_px [MEM_DEPTH];
   int unsigned  load_pos;
   int unsigned  scan_pos;
   int           cur_col, cur_row;
   int           start_col, start_row;
   dir_t         dir = DIR_EAST;
   trace_state_t trace_state = SEEK;
   int unsigned  closed_total;
   int unsigned  width_reg = 256;
   int unsigned  height_reg = 256;
   bit           scan_finished;

   corner_word_t corner_queue[$];

   // Bench control
   int unsigned  mismatch_count;
   int unsigned  cycle_count;
   bit           sender_calm;
   bit           sink_calm;
   int unsigned  stall_requests;
   int unsigned  stall_served;
   int unsigned  hold_left;

   binary_contour_tracer_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_corner_x      (rsp_corner_x),
      .rsp_corner_y      (rsp_corner_y),
      .rsp_contour_end   (rsp_contour_end),
      .rsp_scan_done     (rsp_scan_done),
      .rsp_contour_count (rsp_contour_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Dimensions as the block uses them: clamp to the store size
   function automatic int unsigned used_width();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
   endfunction

   function automatic int unsigned used_height();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
   endfunction

   // Pixel lookup; anything off the image is white
   function automatic bit pixel_on(input int col, input int row);
      if (col < 0 || row < 0 || col >= int'(used_width()) || row >= int'(used_height()))
         return 1'b0;
      return img_px[row * MEM_ROW + col];
   endfunction

   // Apply one accepted word to the mirrored tracer and queue the corner it yields
   function automatic void predict_corner(input logic op, input logic pix);
      int unsigned  w, h, col, row, idx;
      bit           found, left_px, right_px;
      corner_word_t word;
      w = used_width();
      h = used_height();
      found = 1'b0;
      word = '0;

      // Load: store the pixel, mark it as a start when its upper neighbor is white
      if (op == OP_LOAD) begin
         if (w == 0 || h == 0)
            return;
         col = load_pos % w;
         row = load_pos / w;
         if (row >= h)
            return;
         idx = row * MEM_ROW + col;
         img_px[idx] = pix;
         start_px[idx] = pix && (row == 0 || !img_px[idx - MEM_ROW]);
         load_pos = (load_pos + 1) & 32'h1FFFF;
         return;
      end

      scan_finished = 1'b0;

      // Close the contour: repeat the start corner and bump the saturating count
      if (trace_state == CLOSING) begin
         if (closed_total < 32'hFFFF)
            closed_total++;
         trace_state = SEEK;
         word.col = OUT_W'(start_col);
         word.row = OUT_W'(start_row);
         word.closing = 1'b1;
         word.total = CNT_W'(closed_total);
         corner_queue.push_back(word);
         return;
      end

      // Seek the next start pixel in raster order
      if (trace_state != FOLLOW) begin
         trace_state = SEEK;
         if (w != 0 && h != 0) begin
            while (!found && scan_pos < w * h) begin
               col = scan_pos % w;
               row = scan_pos / w;
               scan_pos++;
               if (start_px[row * MEM_ROW + col]) begin
                  start_col = int'(col);
                  start_row = int'(row);
                  found = 1'b1;
               end
            end
         end
         if (!found) begin
            word.exhausted = 1'b1;
            word.total = CNT_W'(closed_total);
            corner_queue.push_back(word);
            scan_finished = 1'b1;
            return;
         end
         cur_col = start_col;
         cur_row = start_row;
         dir = DIR_EAST;
      end

      word.col = OUT_W'(cur_col);
      word.row = OUT_W'(cur_row);
      word.total = CNT_W'(closed_total);
      corner_queue.push_back(word);

      // Drop the start mark below-right of this corner, then step one edge
      if (cur_col >= 0 && cur_row >= 0 &&
          cur_col < int'(used_width()) && cur_row < int'(used_height()))
         start_px[cur_row * MEM_ROW + cur_col] = 1'b0;
      case (dir)
         DIR_EAST:  cur_col++;
         DIR_NORTH: cur_row--;
         DIR_WEST:  cur_col--;
         default:   cur_row++;
      endcase

      // Look at the two pixels ahead and turn
      case (dir)
         DIR_EAST: begin
            left_px  = pixel_on(cur_col, cur_row - 1);
            right_px = pixel_on(cur_col, cur_row);
         end
         DIR_NORTH: begin
            left_px  = pixel_on(cur_col - 1, cur_row - 1);
            right_px = pixel_on(cur_col, cur_row - 1);
         end
         DIR_WEST: begin
            left_px  = pixel_on(cur_col - 1, cur_row);
            right_px = pixel_on(cur_col - 1, cur_row - 1);
         end
         default: begin
            left_px  = pixel_on(cur_col, cur_row);
            right_px = pixel_on(cur_col - 1, cur_row);
         end
      endcase
      if (left_px)
         dir = dir_t'(dir + 2'd1);
      else if (!right_px)
         dir = dir_t'(dir + 2'd3);

      if (cur_col == start_col && cur_row == start_row && dir == DIR_EAST)
         trace_state = CLOSING;
      else
         trace_state = FOLLOW;
   endfunction

   // Receiver: random stalls, calm stretches, and a long hold-off on request
   always @(posedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (sink_calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 33);
      end
   end

   // Compare each accepted result word with the oldest expected corner
   always @(posedge clock) begin : check_words
      corner_word_t seen;
      corner_word_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_corner_x, rsp_corner_y, rsp_contour_end, rsp_scan_done,
                 rsp_contour_count};
         if (corner_queue.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected word: x=%0d y=%0d end=%0d done=%0d count=%0d",
                        seen.col, seen.row, seen.closing, seen.exhausted, seen.total);
            mismatch_count++;
         end else begin
            want = corner_queue.pop_front();
            if (seen !== want) begin
               if (mismatch_count < 10)
                  $display("mismatch: exp x=%0d y=%0d end=%0d done=%0d count=%0d, got x=%0d y=%0d end=%0d done=%0d count=%0d",
                           want.col, want.row, want.closing, want.exhausted, want.total,
                           seen.col, seen.row, seen.closing, seen.exhausted, seen.total);
               mismatch_count++;
            end
         end
      end
   end

   // Offer one word, possibly after a random gap, and wait for its handshake
   task automatic send_word(input logic op, input logic pix);
      if (!sender_calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      predict_corner(op, pix);
   endtask

   // Idle the input, wait for every expected word, then let loads settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (corner_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both dimension registers while the block is idle
   task automatic set_dims(input int unsigned w, input int unsigned h);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      width_reg = w & 32'h1FF;
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      height_reg = h & 32'h1FF;
      csr_we <= 1'b0;
   endtask

   // Load pixels until the current area is full
   task automatic fill_image(input int unsigned density);
      while (load_pos < used_width() * used_height())
         send_word(OP_LOAD, $urandom_range(99) < density);
   endtask

   // Fetch corners until the scan reports no start left, then a few more
   task automatic fetch_all(input int unsigned extra);
      scan_finished = 1'b0;
      while (!scan_finished)
         send_word(OP_FETCH, $urandom_range(1));
      repeat (extra) send_word(OP_FETCH, $urandom_range(1));
   endtask

   // Zero dimensions: loads are dropped and fetches report an empty scan
   task automatic test_empty_image();
      set_dims(0, 256);
      send_word(OP_LOAD, 1'b1);
      send_word(OP_FETCH, 1'b0);
      set_dims(511, 0);
      send_word(OP_LOAD, 1'b0);
      send_word(OP_FETCH, 1'b1);
      set_dims(256, 0);
      send_word(OP_FETCH, 1'b0);
      set_dims(0, 511);
      send_word(OP_FETCH, 1'b1);
   endtask

   // One black pixel: four corners, the closing corner, then an exhausted scan
   task automatic test_single_pixel();
      set_dims(1, 1);
      send_word(OP_LOAD, 1'b1);
      send_word(OP_LOAD, 1'b1);   // past the last pixel, dropped
      fetch_all(1);
   endtask

   // Widen row zero; positions carry over into the new geometry
   task automatic test_row_growth();
      set_dims(4, 1);
      send_word(OP_LOAD, 1'b0);
      send_word(OP_LOAD, 1'b1);
      send_word(OP_LOAD, 1'b1);
      fetch_all(0);
   endtask

   // Grow a fixed-width strip a few random rows at a time and trace each addition
   task automatic test_random_strips();
      int unsigned rows, phase_no, density;
      rows = 1;
      phase_no = 0;
      while (rows < STRIP_ROWS) begin
         rows = rows + $urandom_range(1, 4);
         if (rows > STRIP_ROWS)
            rows = STRIP_ROWS;
         sender_calm = (phase_no == 2);
         sink_calm = (phase_no == 2);
         set_dims(STRIP_WIDTH, rows);
         case ($urandom_range(3))
            0:       density = 15;
            1:       density = 50;
            2:       density = 70;
            default: density = 90;
         endcase
         fill_image(density);
         repeat ($urandom_range(0, 2)) send_word(OP_LOAD, $urandom_range(1));
         // hold the receiver off so the block backs up into its input
         if (phase_no == 1)
            stall_requests++;
         fetch_all($urandom_range(0, 2));
         if (phase_no == 3) begin
            set_dims(STRIP_WIDTH, 0);
            send_word(OP_FETCH, $urandom_range(1));
         end
         phase_no++;
      end
      sender_calm = 1'b0;
      sink_calm = 1'b0;
   endtask

   // Oversized width clamps to the store width; the area is already consumed
   task automatic test_oversized_width();
      set_dims(511, 1);
      send_word(OP_LOAD, 1'b1);
      send_word(OP_FETCH, 1'b0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_image();
      test_single_pixel();
      test_row_growth();
      test_random_strips();
      test_oversized_width();
      drain_results();
      if (mismatch_count == 0 && corner_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ binary_contour_tracer_core.f @@
rtl/bct_pkg.sv
rtl/bct_pixel_store.sv
rtl/bct_divider.sv
rtl/binary_contour_tracer_core.sv
rtl/bct_checker.sv
bench/tb_binary_contour_tracer_core.sv
